[rtl/lr_table_driven_parse_driver_core_assert.svh]
// ----------------------------------------------------------------------------
// LR parse driver assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LR_TABLE_DRIVEN_PARSE_DRIVER_CORE_ASSERT_SVH
`define LR_TABLE_DRIVEN_PARSE_DRIVER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRPD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("LR parse driver assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LRPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("LR parse driver assertion failed");

`endif

[rtl/lrpd_pkg.sv]
// ----------------------------------------------------------------------------
// LR parse driver package
// Field widths, operation codes, action kinds, step kinds and defaults.
// ----------------------------------------------------------------------------
package lrpd_pkg;

    // Default sizes of the tables and stacks.
    localparam int NUM_STATES_DEF  = 256;
    localparam int NUM_SYMBOLS_DEF = 128;
    localparam int NUM_RULES_DEF   = 128;
    localparam int MAX_RHS_DEF     = 15;
    localparam int STACK_DEPTH_DEF = 64;

    // Reductions allowed for one token before it is rejected.
    localparam int MAX_REDUCTIONS = 63;

    // Field widths.
    localparam int STATE_W = 8;
    localparam int SYM_W   = 7;
    localparam int KIND_W  = 3;
    localparam int STEP_W  = 16;
    localparam int OP_W    = 3;
    localparam int IN_DW   = 56;
    localparam int OUT_DW  = 40;

    // Request operations.
    localparam logic [OP_W-1:0] OP_WR_ACTION = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_HDR    = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_RHS    = 3'd2;
    localparam logic [OP_W-1:0] OP_START     = 3'd3;
    localparam logic [OP_W-1:0] OP_TOKEN     = 3'd4;

    // Action table entry kinds.
    localparam logic [KIND_W-1:0] EK_EMPTY  = 3'd0;
    localparam logic [KIND_W-1:0] EK_ACCEPT = 3'd1;
    localparam logic [KIND_W-1:0] EK_SHIFT  = 3'd2;
    localparam logic [KIND_W-1:0] EK_GOTO   = 3'd3;
    localparam logic [KIND_W-1:0] EK_REDUCE = 3'd4;

    // Result step kinds.
    localparam logic [KIND_W-1:0] SK_REDUCE   = 3'd0;
    localparam logic [KIND_W-1:0] SK_SHIFT    = 3'd1;
    localparam logic [KIND_W-1:0] SK_ACCEPT   = 3'd2;
    localparam logic [KIND_W-1:0] SK_NO_ENTRY = 3'd3;
    localparam logic [KIND_W-1:0] SK_MISMATCH = 3'd4;
    localparam logic [KIND_W-1:0] SK_OVERFLOW = 3'd5;
    localparam logic [KIND_W-1:0] SK_TOO_MANY = 3'd6;
    localparam logic [KIND_W-1:0] SK_INACTIVE = 3'd7;

endpackage

[rtl/lr_table_driven_parse_driver_core.sv]
// Each token's results are registered one by one: a result for each reduction, then
// its last result; writes and start are taken in the idle state.
// One request at a time; the next is taken once the last result of the previous
// one is loaded. A result that waits in the output register stalls the sequencer.
// Reset: synchronous, active low; then a clearing pass over every action table
// address empties the action table before any request.
`include "lr_table_driven_parse_driver_core_assert.svh"
// ----------------------------------------------------------------------------
// LR table driven parse driver
// Shift/reduce engine over a loaded action/goto table and rule table, run by a
// small sequencer that shares one action table read port and one pop checker.
// ----------------------------------------------------------------------------
module lr_table_driven_parse_driver_core #(
    parameter int NUM_STATES  = lrpd_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS = lrpd_pkg::NUM_SYMBOLS_DEF,
    parameter int NUM_RULES   = lrpd_pkg::NUM_RULES_DEF,
    parameter int MAX_RHS     = lrpd_pkg::MAX_RHS_DEF,
    parameter int STACK_DEPTH = lrpd_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: end marker symbol.
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrpd_pkg::SYM_W-1:0]  i_cfg_data,
    // Request stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // state_index[7:0], symbol[14:8], entry_kind[17:15], entry_target[25:18],
    // rule_number[32:26], rhs_position[36:33], rule_length[40:37],
    // left_symbol[47:41], rule_is_empty[48], zero fill[55:49]
    input  logic [lrpd_pkg::IN_DW-1:0]  s_tdata,
    // operation[2:0]
    input  logic [lrpd_pkg::OP_W-1:0]   s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // step_number[15:0], reduced_rule[22:16], top_symbol[29:23],
    // lookahead_symbol[36:30], zero fill[39:37]
    output logic [lrpd_pkg::OUT_DW-1:0] m_tdata,
    // step_kind[2:0]
    output logic [lrpd_pkg::KIND_W-1:0] m_tuser,
    output logic                        m_tlast
);
    import lrpd_pkg::*;

    localparam int ST_W     = $clog2(NUM_STATES);
    localparam int SY_W     = $clog2(NUM_SYMBOLS);
    localparam int RU_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int LEN_W    = $clog2(MAX_RHS + 1);
    localparam int STK_W    = $clog2(STACK_DEPTH);
    localparam int SP_W     = $clog2(STACK_DEPTH + 1);
    localparam int ACT_AW   = ST_W + SY_W;
    localparam int ACT_DW   = KIND_W + STATE_W;
    localparam int HDR_DW   = SYM_W + LEN_W + 1;
    localparam int RHS_AW   = RU_W + LEN_W;
    localparam int RED_W    = $clog2(MAX_REDUCTIONS + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_ACT, S_HDR, S_RD, S_CMP, S_GO, S_GOR, S_GOA
    } t_state;

    // Request fields.
    logic [OP_W-1:0]    in_op;
    logic [STATE_W-1:0] in_st;
    logic [SYM_W-1:0]   in_sym;
    logic [KIND_W-1:0]  in_ekind;
    logic [STATE_W-1:0] in_etgt;
    logic [SYM_W-1:0]   in_rule;
    logic [3:0]         in_pos;
    logic [3:0]         in_len;
    logic [SYM_W-1:0]   in_left;
    logic               in_empty;

    assign in_op    = s_tuser;
    assign in_st    = s_tdata[7:0];
    assign in_sym   = s_tdata[14:8];
    assign in_ekind = s_tdata[17:15];
    assign in_etgt  = s_tdata[25:18];
    assign in_rule  = s_tdata[32:26];
    assign in_pos   = s_tdata[36:33];
    assign in_len   = s_tdata[40:37];
    assign in_left  = s_tdata[47:41];
    assign in_empty = s_tdata[48];

    // Control registers.
    t_state             r_state;
    logic [ACT_AW-1:0]  r_clr;
    logic [SYM_W-1:0]   r_end_mark;
    logic               r_active;
    logic [SP_W-1:0]    r_sp;
    logic [STEP_W-1:0]  r_step;
    logic [RED_W-1:0]   r_red;
    logic [LEN_W-1:0]   r_i;
    logic [LEN_W-1:0]   r_pops;
    logic [RU_W-1:0]    r_rule;
    logic [SYM_W-1:0]   r_left;
    logic [SYM_W-1:0]   r_tok;
    logic [SYM_W-1:0]   r_top;
    logic [STATE_W-1:0] r_topst;
    logic               r_look_ok;
    logic               r_mvalid;
    logic [OUT_DW-1:0]  r_mdata;
    logic [KIND_W-1:0]  r_muser;
    logic               r_mlast;

    // Memories and their registered read data.
    logic [ACT_DW-1:0]  act_mem [2**ACT_AW];
    logic [HDR_DW-1:0]  hdr_mem [2**RU_W];
    logic [SYM_W-1:0]   rhs_mem [2**RHS_AW];
    logic [STATE_W-1:0] sst_mem [2**STK_W];
    logic [SYM_W-1:0]   sym_mem [2**STK_W];
    logic [ACT_DW-1:0]  r_act_q;
    logic [HDR_DW-1:0]  r_hdr_q;
    logic [SYM_W-1:0]   r_rhs_q;
    logic [STATE_W-1:0] r_sst_q;
    logic [SYM_W-1:0]   r_sym_q;

    logic               accept;
    logic               out_free;
    logic               fire;
    logic [KIND_W-1:0]  act_kind;
    logic [STATE_W-1:0] act_tgt;
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   hdr_pops;
    logic [SP_W-1:0]    sp_base;

    // Emission request from the sequencer.
    logic               em_req;
    logic [KIND_W-1:0]  em_kind;
    logic [SYM_W-1:0]   em_rule;
    logic [SYM_W-1:0]   em_top;
    logic               em_last;

    // Memory port controls.
    logic               act_we;
    logic [ACT_AW-1:0]  act_waddr;
    logic [ACT_DW-1:0]  act_wdata;
    logic               act_re;
    logic [ACT_AW-1:0]  act_raddr;
    logic               stk_we;
    logic [STK_W-1:0]   stk_waddr;
    logic [STATE_W-1:0] sst_wdata;
    logic [SYM_W-1:0]   sym_wdata;
    logic               stk_re;
    logic [STK_W-1:0]   stk_raddr;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_mvalid || m_tready;
    assign fire        = em_req && out_free;
    assign act_kind    = r_look_ok ? r_act_q[ACT_DW-1:STATE_W] : EK_EMPTY;
    assign act_tgt     = r_act_q[STATE_W-1:0];
    assign hdr_len     = r_hdr_q[LEN_W:1];
    assign hdr_pops    = r_hdr_q[0] ? '0 : hdr_len;
    assign sp_base     = r_sp - SP_W'(r_pops);

    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;
    assign m_tlast  = r_mlast;

    // Result selection for each sequencer step.
    always_comb begin
        em_req  = 1'b0;
        em_kind = SK_NO_ENTRY;
        em_rule = '0;
        em_top  = r_top;
        em_last = 1'b1;
        case (r_state)
            S_LOOK: begin
                if (!r_active) begin
                    em_req  = 1'b1;
                    em_kind = SK_INACTIVE;
                    em_top  = (r_sp == '0) ? '0 : r_top;
                end
            end
            S_ACT: begin
                case (act_kind)
                    EK_REDUCE: begin
                        if (32'(r_red) >= MAX_REDUCTIONS) begin
                            em_req  = 1'b1;
                            em_kind = SK_TOO_MANY;
                        end else if (32'(act_tgt) >= NUM_RULES) begin
                            em_req = 1'b1;
                        end
                    end
                    EK_SHIFT, EK_GOTO: begin
                        em_req = 1'b1;
                        if (32'(r_sp) >= STACK_DEPTH) begin
                            em_kind = SK_OVERFLOW;
                        end else begin
                            em_kind = SK_SHIFT;
                            em_top  = r_tok;
                        end
                    end
                    EK_ACCEPT: begin
                        em_req  = 1'b1;
                        em_kind = SK_ACCEPT;
                    end
                    default: begin
                        em_req = 1'b1;
                    end
                endcase
            end
            S_HDR: begin
                if (32'(hdr_pops) >= 32'(r_sp)) begin
                    em_req  = 1'b1;
                    em_kind = SK_MISMATCH;
                end
            end
            S_CMP: begin
                if (r_rhs_q != r_sym_q) begin
                    em_req  = 1'b1;
                    em_kind = SK_MISMATCH;
                end
            end
            S_GO: begin
                if (32'(sp_base) >= STACK_DEPTH) begin
                    em_req  = 1'b1;
                    em_kind = SK_OVERFLOW;
                end
            end
            S_GOA: begin
                em_req = 1'b1;
                if (act_kind == EK_GOTO) begin
                    em_kind = SK_REDUCE;
                    em_rule = SYM_W'(r_rule);
                    em_top  = r_left;
                    em_last = 1'b0;
                end
            end
            default: begin
                em_req = 1'b0;
            end
        endcase
    end

    // Memory port selection.
    always_comb begin
        act_we    = 1'b0;
        act_waddr = {ST_W'(in_st), SY_W'(in_sym)};
        act_wdata = {in_ekind, in_etgt};
        if (r_state == S_CLEAR) begin
            act_we    = 1'b1;
            act_waddr = r_clr;
            act_wdata = {EK_EMPTY, STATE_W'(0)};
        end else if (accept && in_op == OP_WR_ACTION &&
                     32'(in_st) < NUM_STATES && 32'(in_sym) < NUM_SYMBOLS) begin
            act_we = 1'b1;
        end

        act_re    = (r_state == S_LOOK) || (r_state == S_GOR);
        act_raddr = (r_state == S_GOR) ? {ST_W'(r_sst_q), SY_W'(r_left)}
                                       : {ST_W'(r_topst), SY_W'(r_tok)};

        stk_we    = 1'b0;
        stk_waddr = '0;
        sst_wdata = '0;
        sym_wdata = r_end_mark;
        if (accept && in_op == OP_START) begin
            stk_we = 1'b1;
        end else if (fire && r_state == S_ACT && em_kind == SK_SHIFT) begin
            stk_we    = 1'b1;
            stk_waddr = STK_W'(r_sp);
            sst_wdata = act_tgt;
            sym_wdata = r_tok;
        end else if (fire && r_state == S_GOA && em_kind == SK_REDUCE) begin
            stk_we    = 1'b1;
            stk_waddr = STK_W'(sp_base);
            sst_wdata = act_tgt;
            sym_wdata = r_left;
        end

        stk_re    = (r_state == S_RD) || (r_state == S_GO);
        stk_raddr = (r_state == S_RD) ? STK_W'(r_sp - SP_W'(1) - SP_W'(r_i))
                                      : STK_W'(sp_base - SP_W'(1));
    end

    // Action table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        if (act_re) begin
            r_act_q <= act_mem[act_raddr];
        end
    end

    // Rule header and right-hand side tables.
    always_ff @(posedge i_clk) begin
        if (accept && in_op == OP_WR_HDR && 32'(in_rule) < NUM_RULES) begin
            hdr_mem[RU_W'(in_rule)] <= {in_left,
                (32'(in_len) > MAX_RHS) ? LEN_W'(MAX_RHS) : LEN_W'(in_len), in_empty};
        end
        if (accept && in_op == OP_WR_RHS && 32'(in_rule) < NUM_RULES &&
            32'(in_pos) < MAX_RHS) begin
            rhs_mem[{RU_W'(in_rule), LEN_W'(in_pos)}] <= in_sym;
        end
        if (r_state == S_ACT) begin
            r_hdr_q <= hdr_mem[RU_W'(act_tgt)];
        end
        if (r_state == S_RD) begin
            r_rhs_q <= rhs_mem[{r_rule, LEN_W'(r_pops - LEN_W'(1) - r_i)}];
        end
    end

    // State and symbol stacks.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            sst_mem[stk_waddr] <= sst_wdata;
            sym_mem[stk_waddr] <= sym_wdata;
        end
        if (stk_re) begin
            r_sst_q <= sst_mem[stk_raddr];
            r_sym_q <= sym_mem[stk_raddr];
        end
    end

    // Sequencer, parse state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_end_mark <= '0;
            r_active   <= 1'b0;
            r_sp       <= '0;
            r_step     <= STEP_W'(1);
            r_red      <= '0;
            r_mvalid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_end_mark <= i_cfg_data;
            end

            // Load a result and, unless it is an inactive one, advance the step count; or drop a taken one.
            if (fire) begin
                r_mvalid <= 1'b1;
                r_mdata  <= {3'b000, r_tok, em_top, em_rule, r_step};
                r_muser  <= em_kind;
                r_mlast  <= em_last;
                if (em_kind != SK_INACTIVE) begin
                    r_step <= r_step + STEP_W'(1);
                end
                if (em_last && em_kind != SK_SHIFT && em_kind != SK_INACTIVE) begin
                    r_active <= 1'b0;
                end
                if (em_last) begin
                    r_state <= S_IDLE;
                end
            end else if (m_tready) begin
                r_mvalid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ACT_AW'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && in_op == OP_START) begin
                        r_sp     <= SP_W'(1);
                        r_step   <= STEP_W'(1);
                        r_active <= 1'b1;
                        r_top    <= r_end_mark;
                        r_topst  <= '0;
                    end else if (accept && in_op == OP_TOKEN) begin
                        r_tok   <= in_sym;
                        r_red   <= '0;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_look_ok <= 32'(r_topst) < NUM_STATES && 32'(r_tok) < NUM_SYMBOLS;
                    if (r_active) begin
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    if (fire && em_kind == SK_SHIFT) begin
                        r_sp    <= r_sp + SP_W'(1);
                        r_top   <= r_tok;
                        r_topst <= act_tgt;
                    end
                    if (!em_req) begin
                        r_rule  <= RU_W'(act_tgt);
                        r_state <= S_HDR;
                    end
                end
                S_HDR: begin
                    r_pops <= hdr_pops;
                    r_left <= r_hdr_q[HDR_DW-1:LEN_W+1];
                    r_i    <= '0;
                    if (!em_req) begin
                        r_state <= (hdr_pops == '0) ? S_GO : S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!em_req) begin
                        r_i     <= r_i + LEN_W'(1);
                        r_state <= (r_i + LEN_W'(1) == r_pops) ? S_GO : S_RD;
                    end
                end
                S_GO: begin
                    if (!em_req) begin
                        r_state <= S_GOR;
                    end
                end
                S_GOR: begin
                    r_look_ok <= 32'(r_sst_q) < NUM_STATES && 32'(r_left) < NUM_SYMBOLS;
                    r_state   <= S_GOA;
                end
                S_GOA: begin
                    if (fire && em_kind == SK_REDUCE) begin
                        r_sp    <= sp_base + SP_W'(1);
                        r_top   <= r_left;
                        r_topst <= act_tgt;
                        r_red   <= r_red + RED_W'(1);
                        r_state <= S_LOOK;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer and the result stream.
    `LRPD_ASSERT_IMP(a_clear_blocks, r_state == S_CLEAR, !s_tready)
    `LRPD_ASSERT_IMP(a_shift_ends_token, m_tvalid && m_tuser == SK_SHIFT, m_tlast)
    `LRPD_ASSERT_IMP(a_reduce_not_last, m_tvalid && m_tuser == SK_REDUCE, !m_tlast)
    `LRPD_ASSERT_NEXT(a_sp_bound, 1'b1, 32'(r_sp) <= STACK_DEPTH)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// LR parse driver testbench
// Loads a small bracketed-list grammar plus error rows into the action and rule
// tables. It then runs directed and random token streams under three end marker
// settings. A parse predictor inside the scoreboard works out every step.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import lrpd_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_GOAL   = 380;
    localparam int N_RHS       = 15;
    localparam int N_STACK     = 64;

    // Grammar symbols; the end marker comes from the configuration register.
    localparam logic [6:0] SYM_A  = 7'd1;
    localparam logic [6:0] SYM_S  = 7'd2;
    localparam logic [6:0] SYM_LP = 7'd3;
    localparam logic [6:0] SYM_RP = 7'd4;
    localparam logic [6:0] SYM_T  = 7'd8;
    localparam logic [6:0] SYM_Z  = 7'd9;

    typedef struct {
        logic [2:0] op;
        logic [7:0] st;
        logic [6:0] sym;
        logic [2:0] ekind;
        logic [7:0] etgt;
        logic [6:0] rule;
        logic [3:0] pos;
        logic [3:0] len;
        logic [6:0] left;
        logic       empty;
    } parse_req_t;

    typedef struct {
        logic [15:0] step;
        logic [2:0]  kind;
        logic [6:0]  rule;
        logic [6:0]  top;
        logic [6:0]  la;
        logic        last;
    } parse_step_t;

    // Scoreboard: keeps its own copy of the tables and stacks and predicts steps.
    class parse_scoreboard;
        logic [2:0]  act_kind[32768];
        logic [7:0]  act_tgt[32768];
        logic [6:0]  rule_left[128];
        logic [3:0]  rule_len[128];
        logic        rule_empty[128];
        logic [6:0]  rule_rhs[128*N_RHS];
        logic [7:0]  st_stk[N_STACK];
        logic [6:0]  sym_stk[N_STACK];
        int          depth;
        logic [15:0] step_ctr;
        bit          active;
        logic [6:0]  end_marker;
        parse_step_t pending_steps[$];
        int          failures;
        int          checked;
        int          kind_count[8];

        function new();
            foreach (act_kind[i]) begin
                act_kind[i] = EK_EMPTY;
                act_tgt[i] = 0;
            end
            depth = 0;
            step_ctr = 1;
            active = 0;
            end_marker = 0;
            failures = 0;
            checked = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function logic [6:0] top_sym();
            return depth > 0 ? sym_stk[depth-1] : 7'd0;
        endfunction

        function void push_step(logic [2:0] kind, logic [6:0] rule, logic [6:0] la,
                                logic last);
            parse_step_t s;
            s.step = step_ctr;
            s.kind = kind;
            s.rule = rule;
            s.top = top_sym();
            s.la = la;
            s.last = last;
            pending_steps.insert(pending_steps.size(), s);
            if (kind != SK_INACTIVE) step_ctr++;
            if (last && kind != SK_SHIFT && kind != SK_INACTIVE) active = 0;
        endfunction

        // Runs one token: reductions first, then a shift, accept or error.
        function void run_token(logic [6:0] la);
            int reductions;
            int pops;
            logic [2:0] k;
            logic [7:0] t;
            logic [2:0] gk;
            logic [7:0] gt;
            logic [6:0] r;
            reductions = 0;
            if (!active || depth == 0) begin
                push_step(SK_INACTIVE, 0, la, 1);
                return;
            end
            forever begin
                k = act_kind[{st_stk[depth-1], la}];
                t = act_tgt[{st_stk[depth-1], la}];
                if (k == EK_REDUCE) begin
                    if (reductions >= MAX_REDUCTIONS) begin
                        push_step(SK_TOO_MANY, 0, la, 1);
                        return;
                    end
                    if (t >= 128) begin
                        push_step(SK_NO_ENTRY, 0, la, 1);
                        return;
                    end
                    r = t[6:0];
                    pops = rule_empty[r] ? 0 : rule_len[r];
                    if (pops >= depth) begin
                        push_step(SK_MISMATCH, 0, la, 1);
                        return;
                    end
                    for (int i = 0; i < pops; i++) begin
                        if (rule_rhs[r*N_RHS + pops-1-i] != sym_stk[depth-1-i]) begin
                            push_step(SK_MISMATCH, 0, la, 1);
                            return;
                        end
                    end
                    if (depth - pops >= N_STACK) begin
                        push_step(SK_OVERFLOW, 0, la, 1);
                        return;
                    end
                    gk = act_kind[{st_stk[depth-pops-1], rule_left[r]}];
                    gt = act_tgt[{st_stk[depth-pops-1], rule_left[r]}];
                    if (gk != EK_GOTO) begin
                        push_step(SK_NO_ENTRY, 0, la, 1);
                        return;
                    end
                    depth -= pops;
                    st_stk[depth] = gt;
                    sym_stk[depth] = rule_left[r];
                    depth++;
                    reductions++;
                    push_step(SK_REDUCE, r, la, 0);
                end else if (k == EK_SHIFT || k == EK_GOTO) begin
                    if (depth >= N_STACK) begin
                        push_step(SK_OVERFLOW, 0, la, 1);
                        return;
                    end
                    st_stk[depth] = t;
                    sym_stk[depth] = la;
                    depth++;
                    push_step(SK_SHIFT, 0, la, 1);
                    return;
                end else if (k == EK_ACCEPT) begin
                    push_step(SK_ACCEPT, 0, la, 1);
                    return;
                end else begin
                    push_step(SK_NO_ENTRY, 0, la, 1);
                    return;
                end
            end
        endfunction

        // Notes an accepted request and queues the steps it causes.
        function void note_request(parse_req_t q);
            case (q.op)
                OP_WR_ACTION: begin
                    act_kind[{q.st, q.sym}] = q.ekind;
                    act_tgt[{q.st, q.sym}] = q.etgt;
                end
                OP_WR_HDR: begin
                    rule_left[q.rule] = q.left;
                    rule_len[q.rule] = q.len > N_RHS ? 4'(N_RHS) : q.len;
                    rule_empty[q.rule] = q.empty;
                end
                OP_WR_RHS: begin
                    if (q.pos < N_RHS) rule_rhs[q.rule*N_RHS + q.pos] = q.sym;
                end
                OP_START: begin
                    st_stk[0] = 0;
                    sym_stk[0] = end_marker;
                    depth = 1;
                    step_ctr = 1;
                    active = 1;
                end
                OP_TOKEN: run_token(q.sym);
                default: ;
            endcase
        endfunction

        function void compare(string name, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp, act);
                failures++;
            end
        endfunction

        // Checks one accepted result against the oldest predicted step.
        function void check_result(parse_step_t got);
            parse_step_t e;
            if (pending_steps.size() == 0) begin
                $error("unexpected result: step %0d kind %0d", got.step, got.kind);
                failures++;
                return;
            end
            e = pending_steps.pop_front();
            checked++;
            kind_count[e.kind]++;
            compare("step_number", e.step, got.step);
            compare("step_kind", e.kind, got.kind);
            compare("reduced_rule", e.rule, got.rule);
            compare("top_symbol", e.top, got.top);
            compare("lookahead_symbol", e.la, got.la);
            compare("last", e.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    lr_table_driven_parse_driver_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    parse_scoreboard sb = new();
    int        items_sent = 0;
    int        tokens_sent = 0;
    bit        no_gaps = 0;
    bit        did_hold = 0;
    int        good_rules[$];
    logic [6:0] tok_q[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic parse_req_t rand_req(logic [2:0] op);
        parse_req_t q;
        q.op = op;
        q.st = $urandom;
        q.sym = $urandom;
        q.ekind = $urandom;
        q.etgt = $urandom;
        q.rule = $urandom;
        q.pos = $urandom;
        q.len = $urandom;
        q.left = $urandom;
        q.empty = $urandom;
        return q;
    endfunction

    // Offers one request and waits for its handshake.
    task automatic send(parse_req_t q);
        int g;
        g = no_gaps ? 0 : pick_gap();
        if (g > 0) begin
            s_tvalid = 0;
            repeat (g) @(negedge i_clk);
        end
        s_tdata = {7'd0, q.empty, q.left, q.len, q.pos, q.rule, q.etgt, q.ekind,
                   q.sym, q.st};
        s_tuser = q.op;
        s_tvalid = 1;
        do @(posedge i_clk); while (!s_tready);
        sb.note_request(q);
        items_sent++;
        if (q.op == OP_TOKEN) tokens_sent++;
        @(negedge i_clk);
    endtask

    task automatic wr_action(logic [7:0] st, logic [6:0] sym, logic [2:0] kind,
                             logic [7:0] tgt);
        parse_req_t q;
        q = rand_req(OP_WR_ACTION);
        q.st = st;
        q.sym = sym;
        q.ekind = kind;
        q.etgt = tgt;
        send(q);
    endtask

    // Writes a rule header and every right-hand symbol that a pop can check.
    task automatic wr_rule(logic [6:0] r, logic [6:0] left, logic [3:0] len,
                           logic empty, logic [6:0] rhs[$]);
        parse_req_t q;
        q = rand_req(OP_WR_HDR);
        q.rule = r;
        q.left = left;
        q.len = len;
        q.empty = empty;
        send(q);
        for (int i = 0; i < len; i++) begin
            q = rand_req(OP_WR_RHS);
            q.rule = r;
            q.pos = i;
            q.sym = i < rhs.size() ? rhs[i] : 7'($urandom);
            send(q);
        end
        if (!(r inside {good_rules})) good_rules.insert(good_rules.size(), r);
    endtask

    task automatic start_parse();
        send(rand_req(OP_START));
    endtask

    task automatic token(logic [6:0] sym);
        parse_req_t q;
        q = rand_req(OP_TOKEN);
        q.sym = sym;
        send(q);
    endtask

    task automatic drain_queue();
        foreach (tok_q[i]) token(tok_q[i]);
        tok_q.delete();
    endtask

    // Waits until all results are in and the block has settled, then writes
    // the end marker register.
    task automatic set_end_marker(logic [6:0] em);
        s_tvalid = 0;
        while (sb.pending_steps.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_data = em;
        i_cfg_valid = 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.end_marker = em;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    // Builds a random sentence of the list grammar: S := item+, item := a | ( S ).
    function automatic void gen_list(int lvl);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            if (lvl < 4 && $urandom_range(0, 2) == 0) begin
                tok_q.insert(tok_q.size(), SYM_LP);
                gen_list(lvl + 1);
                tok_q.insert(tok_q.size(), SYM_RP);
            end else begin
                tok_q.insert(tok_q.size(), SYM_A);
            end
        end
    endfunction

    task automatic load_grammar();
        logic [6:0] rhs[$];
        rhs = '{SYM_A};                  wr_rule(0, SYM_S, 1, 0, rhs);
        rhs = '{SYM_S, SYM_A};           wr_rule(1, SYM_S, 2, 0, rhs);
        rhs = '{SYM_LP, SYM_S, SYM_RP};  wr_rule(2, SYM_S, 3, 0, rhs);
        rhs = {};                        wr_rule(3, SYM_T, 3, 1, rhs);
        rhs = {};                        wr_rule(4, SYM_S, 5, 0, rhs);
        rhs = '{7'd5};                   wr_rule(5, SYM_S, 1, 0, rhs);
        rhs = {};                        wr_rule(6, 7'd13, 0, 1, rhs);
        rhs = {};                        wr_rule(7, 7'd127, 15, 0, rhs);
        wr_action(0, SYM_A, EK_SHIFT, 1);
        wr_action(0, SYM_LP, EK_SHIFT, 4);
        wr_action(0, SYM_S, EK_GOTO, 2);
        wr_action(1, SYM_A, EK_REDUCE, 0);
        wr_action(1, SYM_RP, EK_REDUCE, 0);
        wr_action(2, SYM_A, EK_SHIFT, 3);
        wr_action(3, SYM_A, EK_REDUCE, 1);
        wr_action(3, SYM_RP, EK_REDUCE, 1);
        wr_action(4, SYM_A, EK_SHIFT, 1);
        wr_action(4, SYM_LP, EK_SHIFT, 4);
        wr_action(4, SYM_S, EK_GOTO, 6);
        wr_action(6, SYM_A, EK_SHIFT, 3);
        wr_action(6, SYM_RP, EK_SHIFT, 7);
        wr_action(7, SYM_A, EK_REDUCE, 2);
        wr_action(7, SYM_RP, EK_REDUCE, 2);
        // Empty rule that loops on itself until the reduction limit.
        wr_action(0, SYM_Z, EK_REDUCE, 3);
        wr_action(8, SYM_Z, EK_REDUCE, 3);
        wr_action(0, SYM_T, EK_GOTO, 8);
        wr_action(8, SYM_T, EK_GOTO, 8);
        // Error rows reached straight from state 0.
        wr_action(0, 11, EK_REDUCE, 4);
        wr_action(0, 12, EK_REDUCE, 5);
        wr_action(0, 14, EK_REDUCE, 6);
        wr_action(0, 15, EK_REDUCE, 200);
        wr_action(0, 16, 3'd7, 0);
        wr_action(0, 17, EK_GOTO, 2);
        wr_action(0, 18, 3'd6, 8'hff);
        wr_action(0, 19, 3'd5, 0);
    endtask

    // Entries in the end marker column, rewritten for each marker setting.
    task automatic load_marker_column(logic [6:0] em);
        wr_action(1, em, EK_REDUCE, 0);
        wr_action(3, em, EK_REDUCE, 1);
        wr_action(7, em, EK_REDUCE, 2);
        wr_action(2, em, EK_ACCEPT, 0);
    endtask

    task automatic directed_tokens(logic [6:0] em, bit first);
        if (first) token(SYM_A);
        start_parse();
        tok_q = '{SYM_A, SYM_A, SYM_A, em};
        drain_queue();
        token(SYM_A);
        start_parse();
        tok_q = '{SYM_LP, SYM_A, SYM_LP, SYM_A, SYM_A, SYM_RP, SYM_RP, SYM_A, em};
        drain_queue();
        start_parse(); token(SYM_Z);
        start_parse(); token(11);
        start_parse(); token(12);
        start_parse(); token(14);
        start_parse(); token(15);
        start_parse(); token(16);
        start_parse(); token(17); token(SYM_A); token(em);
        if (first) begin
            start_parse();
            repeat (64) token(SYM_LP);
        end
    endtask

    task automatic random_writes();
        parse_req_t q;
        logic [6:0] rhs[$];
        int p;
        p = $urandom_range(0, 2);
        if (p == 0) begin
            q = rand_req(OP_WR_ACTION);
            q.st = $urandom_range(16, 255);
            if (q.ekind == EK_REDUCE)
                q.etgt = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                       : 8'(good_rules[$urandom_range(0, good_rules.size()-1)]);
            send(q);
        end else if (p == 1) begin
            rhs = {};
            wr_rule($urandom_range(20, 127), $urandom, $urandom, $urandom, rhs);
        end else begin
            q = rand_req(OP_WR_RHS);
            q.rule = $urandom_range(20, 127);
            send(q);
        end
    endtask

    task automatic random_traffic(int goal, logic [6:0] em);
        int p;
        int k;
        while (items_sent < goal) begin
            no_gaps = $urandom_range(0, 4) == 0;
            p = $urandom_range(0, 99);
            if (p < 60) begin
                start_parse();
                gen_list(0);
                if ($urandom_range(0, 5) != 0) tok_q.insert(tok_q.size(), em);
                drain_queue();
            end else if (p < 75) begin
                start_parse();
                gen_list(0);
                tok_q.insert(tok_q.size(), em);
                k = $urandom_range(0, tok_q.size()-1);
                if ($urandom_range(0, 1)) tok_q.delete(k);
                else tok_q[k] = $urandom;
                drain_queue();
            end else if (p < 85) begin
                random_writes();
            end else if (p < 95) begin
                if ($urandom_range(0, 1)) start_parse();
                repeat ($urandom_range(1, 3)) token($urandom);
            end else begin
                send(rand_req(3'($urandom_range(5, 7))));
            end
        end
        no_gaps = 0;
    endtask

    // Result side: random stalls, and once a long hold-off that backs up requests.
    initial begin
        int stall;
        stall = 0;
        m_tready = 0;
        forever begin
            @(negedge i_clk);
            if (!did_hold && sb.checked >= 60) begin
                did_hold = 1;
                m_tready = 0;
                repeat (400) @(negedge i_clk);
            end
            if (stall > 0) begin
                m_tready = 0;
                stall--;
            end else begin
                m_tready = 1;
                if ($urandom_range(0, 7) == 0) stall = pick_gap();
            end
        end
    end

    // Result sampling.
    initial begin
        parse_step_t got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_tvalid && m_tready) begin
                got.step = m_tdata[15:0];
                got.rule = m_tdata[22:16];
                got.top = m_tdata[29:23];
                got.la = m_tdata[36:30];
                got.kind = m_tuser;
                got.last = m_tlast;
                sb.check_result(got);
            end
        end
    end

    // Watchdog.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout with %0d results outstanding", sb.pending_steps.size());
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence.
    initial begin
        logic [6:0] markers[3];
        markers = '{7'd0, 7'd127, 7'd42};
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = OP_WR_ACTION;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1;
        no_gaps = 1;
        load_grammar();
        no_gaps = 0;
        for (int ph = 0; ph < 3; ph++) begin
            set_end_marker(markers[ph]);
            load_marker_column(markers[ph]);
            directed_tokens(markers[ph], ph == 0);
            random_traffic(ITEM_GOAL * (ph + 1) / 3, markers[ph]);
        end
        s_tvalid = 0;
        while (sb.pending_steps.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("Ran %0d requests (%0d tokens) over end markers 0, 127 and 42.",
                 items_sent, tokens_sent);
        $display("Checked %0d steps: %0d reduce, %0d shift, %0d accept, %0d error.",
                 sb.checked, sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
                 sb.checked - sb.kind_count[0] - sb.kind_count[1] - sb.kind_count[2]);
        if (sb.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
